@@ src/i2c_slave_command_dispatcher_assert.svh @@
// Assertion macros for the command dispatcher.
`ifndef I2C_SLAVE_COMMAND_DISPATCHER_ASSERT_SVH
`define I2C_SLAVE_COMMAND_DISPATCHER_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define I2CSCD_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset.
`define I2CSCD_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ src/i2cscd_pkg.sv @@
package i2cscd_pkg;

    localparam int BUFFER_BYTES_DEF  = 16;
    localparam int TABLE_ENTRIES_DEF = 4;

    localparam int DATA_W     = 8;
    localparam int ENTRY_W    = 13;
    localparam int PCNT_W     = 5;
    localparam int NUM_W      = 3;
    localparam int IDX_W      = 2;
    localparam int EVENT_W    = 4;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 13;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_NUM_COMMANDS = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CMD_ENTRY0   = 3'd1;

    // Opcodes
    localparam logic OP_EVENT = 1'b0;
    localparam logic OP_LOAD  = 1'b1;

    // Bus status events
    localparam logic [EVENT_W-1:0] EV_BUS_ERROR = 4'd0;
    localparam logic [EVENT_W-1:0] EV_RX_ADDR   = 4'd1;
    localparam logic [EVENT_W-1:0] EV_ARB_LOST  = 4'd2;
    localparam logic [EVENT_W-1:0] EV_RX_DATA   = 4'd3;
    localparam logic [EVENT_W-1:0] EV_RX_NACK   = 4'd4;
    localparam logic [EVENT_W-1:0] EV_STOP      = 4'd5;
    localparam logic [EVENT_W-1:0] EV_TX_ADDR   = 4'd6;
    localparam logic [EVENT_W-1:0] EV_TX_DATA   = 4'd7;
    localparam logic [EVENT_W-1:0] EV_TX_NACK   = 4'd8;
    localparam logic [EVENT_W-1:0] EV_TX_LAST   = 4'd9;

    typedef enum logic [1:0] {
        LS_WAIT    = 2'd0,
        LS_RECEIVE = 2'd1,
        LS_SEND    = 2'd2
    } link_state_t;

    typedef struct packed {
        logic               opcode;
        logic [EVENT_W-1:0] bus_event;
        logic [DATA_W-1:0]  bus_data;
        logic [DATA_W-1:0]  response_byte;
        logic               response_last;
    } in_item_t;

    typedef struct packed {
        logic              ack;
        logic              stop_request;
        logic              start_request;
        logic              tx_valid;
        logic [DATA_W-1:0] tx_byte;
        logic              param_valid;
        logic [DATA_W-1:0] param_byte;
        logic [IDX_W-1:0]  cmd_index;
        logic              cmd_fire;
        logic              response_rejected;
    } out_item_t;

    typedef struct packed {
        logic              hit;
        logic [IDX_W-1:0]  index;
        logic [PCNT_W-1:0] param_count;
    } cmd_match_t;

endpackage

@@ src/i2cscd_cmd_table.sv @@
module i2cscd_cmd_table
    import i2cscd_pkg::*;
#(
    parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_wr_index,
    input  logic [CFG_DATA_W-1:0] cfg_wr_data,
    input  logic [DATA_W-1:0]     lookup_id,
    output cmd_match_t            match
);

    localparam logic [NUM_W-1:0] NUM_MAX = NUM_W'(TABLE_ENTRIES);

    logic [NUM_W-1:0]   num_reg;
    logic [ENTRY_W-1:0] entry_reg [TABLE_ENTRIES];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            num_reg <= '0;
            for (int i = 0; i < TABLE_ENTRIES; i++) begin
                entry_reg[i] <= '0;
            end
        end else if (cfg_wr_en) begin
            if (cfg_wr_index == REG_NUM_COMMANDS) begin
                // clamp to the table size
                num_reg <= (cfg_wr_data[NUM_W-1:0] > NUM_MAX) ? NUM_MAX
                                                              : cfg_wr_data[NUM_W-1:0];
            end
            for (int i = 0; i < TABLE_ENTRIES; i++) begin
                if (cfg_wr_index == REG_CMD_ENTRY0 + CFG_IDX_W'(i)) begin
                    entry_reg[i] <= cfg_wr_data[ENTRY_W-1:0];
                end
            end
        end
    end

    // Parallel compare; scan from the top so the lowest index wins
    always_comb begin
        match = '0;
        for (int i = TABLE_ENTRIES - 1; i >= 0; i--) begin
            if ((NUM_W'(i) < num_reg) && (entry_reg[i][DATA_W-1:0] == lookup_id)) begin
                match.hit         = 1'b1;
                match.index       = IDX_W'(i);
                match.param_count = entry_reg[i][ENTRY_W-1:DATA_W];
            end
        end
    end

endmodule

@@ src/i2cscd_resp_buf.sv @@
module i2cscd_resp_buf
    import i2cscd_pkg::*;
#(
    parameter int DEPTH = BUFFER_BYTES_DEF,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              aclk,
    input  logic              wr_en,
    input  logic [AW-1:0]     wr_addr,
    input  logic [DATA_W-1:0] wr_data,
    input  logic [AW-1:0]     rd_addr,
    output logic [DATA_W-1:0] rd_data
);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Write-first read port
    always_ff @(posedge aclk) begin
        if (wr_en && (wr_addr == rd_addr)) begin
            rd_data_reg <= wr_data;
        end else begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

@@ src/i2cscd_core.sv @@
module i2cscd_core
    import i2cscd_pkg::*;
#(
    parameter int BUFFER_BYTES = BUFFER_BYTES_DEF,
    parameter int AW           = (BUFFER_BYTES > 1) ? $clog2(BUFFER_BYTES) : 1
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              advance,
    input  in_item_t          item,
    input  cmd_match_t        match,
    input  logic [DATA_W-1:0] rd_data,
    output logic              wr_en,
    output logic [AW-1:0]     wr_addr,
    output logic [DATA_W-1:0] wr_data,
    output logic [AW-1:0]     rd_addr,
    output out_item_t         result
);

    localparam int CNT_W = $clog2(BUFFER_BYTES + 1);
    localparam int LC_W  = $clog2(BUFFER_BYTES + 2);
    localparam int BL_W  = (CNT_W > PCNT_W) ? CNT_W : PCNT_W;

    localparam logic [LC_W-1:0] LC_FULL = LC_W'(BUFFER_BYTES);
    localparam logic [BL_W-1:0] BL_ONE  = BL_W'(1);

    link_state_t      link_state_reg, link_state_next;
    logic             ack_flag_reg, ack_flag_next;
    logic [IDX_W-1:0] active_cmd_reg, active_cmd_next;
    logic [BL_W-1:0]  bytes_left_reg, bytes_left_next;
    logic [CNT_W-1:0] send_total_reg, send_total_next;
    logic [LC_W-1:0]  load_count_reg, load_count_next;
    logic [LC_W-1:0]  load_count_inc;
    logic [BL_W-1:0]  pos_next;

    assign load_count_inc = (load_count_reg <= LC_FULL) ? load_count_reg + 1'b1
                                                         : load_count_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            link_state_reg <= LS_WAIT;
            ack_flag_reg   <= 1'b1;
            active_cmd_reg <= '0;
            bytes_left_reg <= '0;
            send_total_reg <= '0;
            load_count_reg <= '0;
        end else begin
            link_state_reg <= link_state_next;
            ack_flag_reg   <= ack_flag_next;
            active_cmd_reg <= active_cmd_next;
            bytes_left_reg <= bytes_left_next;
            send_total_reg <= send_total_next;
            load_count_reg <= load_count_next;
        end
    end

    // Next state
    always_comb begin
        link_state_next = link_state_reg;
        ack_flag_next   = ack_flag_reg;
        active_cmd_next = active_cmd_reg;
        bytes_left_next = bytes_left_reg;
        send_total_next = send_total_reg;
        load_count_next = load_count_reg;
        wr_en           = 1'b0;
        wr_addr         = load_count_reg[AW-1:0];
        wr_data         = item.response_byte;
        if (advance) begin
            if (item.opcode == OP_LOAD) begin
                wr_en = (load_count_reg < LC_FULL);
                if (item.response_last) begin
                    if (load_count_inc <= LC_FULL) begin
                        send_total_next = CNT_W'(load_count_inc);
                        bytes_left_next = BL_W'(load_count_inc);
                        link_state_next = LS_SEND;
                    end
                    load_count_next = '0;
                end else begin
                    load_count_next = load_count_inc;
                end
            end else begin
                case (item.bus_event)
                    EV_RX_ADDR, EV_STOP, EV_TX_NACK, EV_TX_LAST: begin
                        ack_flag_next = 1'b1;
                    end
                    EV_ARB_LOST, EV_RX_NACK: begin
                        ack_flag_next = 1'b0;
                    end
                    EV_RX_DATA: begin
                        case (link_state_reg)
                            LS_WAIT: begin
                                ack_flag_next = match.hit;
                                if (match.hit && (match.param_count != '0)) begin
                                    active_cmd_next = match.index;
                                    bytes_left_next = BL_W'(match.param_count);
                                    link_state_next = LS_RECEIVE;
                                end
                            end
                            LS_RECEIVE: begin
                                if (bytes_left_reg == '0) begin
                                    ack_flag_next = 1'b0;
                                end else begin
                                    ack_flag_next   = 1'b1;
                                    bytes_left_next = bytes_left_reg - 1'b1;
                                    if (bytes_left_reg == BL_ONE) begin
                                        active_cmd_next = '0;
                                        link_state_next = LS_WAIT;
                                    end
                                end
                            end
                            default: begin
                            end
                        endcase
                    end
                    EV_TX_ADDR, EV_TX_DATA: begin
                        if ((link_state_reg != LS_SEND) || (bytes_left_reg == '0)) begin
                            ack_flag_next = 1'b0;
                        end else begin
                            bytes_left_next = bytes_left_reg - 1'b1;
                            if (bytes_left_reg == BL_ONE) begin
                                link_state_next = LS_WAIT;
                                ack_flag_next   = 1'b0;
                            end else begin
                                ack_flag_next = 1'b1;
                            end
                        end
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    // Prefetch the byte the next transmit will need
    assign pos_next = BL_W'(send_total_next) - bytes_left_next;
    assign rd_addr  = pos_next[AW-1:0];

    // Result fields
    always_comb begin
        result     = '0;
        result.ack = ack_flag_next;
        if (item.opcode == OP_LOAD) begin
            result.response_rejected = item.response_last && (load_count_inc > LC_FULL);
        end else begin
            case (item.bus_event)
                EV_BUS_ERROR: begin
                    result.stop_request = 1'b1;
                end
                EV_ARB_LOST: begin
                    result.start_request = 1'b1;
                end
                EV_RX_DATA: begin
                    case (link_state_reg)
                        LS_WAIT: begin
                            if (match.hit) begin
                                result.cmd_index = match.index;
                                result.cmd_fire  = (match.param_count == '0);
                            end
                        end
                        LS_RECEIVE: begin
                            if (bytes_left_reg != '0) begin
                                result.param_valid = 1'b1;
                                result.param_byte  = item.bus_data;
                                result.cmd_index   = active_cmd_reg;
                                result.cmd_fire    = (bytes_left_reg == BL_ONE);
                            end
                        end
                        default: begin
                        end
                    endcase
                end
                EV_TX_ADDR, EV_TX_DATA: begin
                    if ((link_state_reg == LS_SEND) && (bytes_left_reg != '0)) begin
                        result.tx_valid = 1'b1;
                        result.tx_byte  = rd_data;
                    end
                end
                default: begin
                end
            endcase
        end
    end

endmodule

@@ src/i2c_slave_command_dispatcher.sv @@
// I2C slave command dispatcher. Each transaction on the s_ channel carries
// either one bus status event from the byte-level I2C slave engine or one
// response byte to load; each produces exactly one result transaction on the
// m_ channel with the ack enable to drive and any start/stop request,
// transmit byte, parameter byte or command-fire strobe. The block takes one
// transaction per cycle while m_ready stays high; a result is presented on
// m_valid once its input has gone through the input register and the decode
// logic into the result register. Back-pressure on m_ready stalls the input
// register in place, and s_ready drops only when both registers are full and
// m_ready is low. The response buffer is a BUFFER_BYTES deep memory with a
// registered read port; the byte for the next transmit is fetched ahead so it
// is ready when a tx event arrives. Program num_commands and cmd_entry_0..3
// through the cfg_wr_* port only while no transaction is in flight; entries
// at or above num_commands are ignored and the lowest matching index wins on
// duplicate ids.
`include "i2c_slave_command_dispatcher_assert.svh"

module i2c_slave_command_dispatcher
    import i2cscd_pkg::*;
#(
    parameter int BUFFER_BYTES  = BUFFER_BYTES_DEF,
    parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  in_item_t              s_payload,
    output logic                  m_valid,
    input  logic                  m_ready,
    output out_item_t             m_payload,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_wr_index,
    input  logic [CFG_DATA_W-1:0] cfg_wr_data
);

    localparam int AW = (BUFFER_BYTES > 1) ? $clog2(BUFFER_BYTES) : 1;

    logic              in_valid_reg, in_valid_next;
    in_item_t          in_item_reg;
    logic              out_valid_reg, out_valid_next;
    out_item_t         out_item_reg;
    logic              advance;
    cmd_match_t        match;
    out_item_t         result;
    logic              buf_wr_en;
    logic [AW-1:0]     buf_wr_addr;
    logic [DATA_W-1:0] buf_wr_data;
    logic [AW-1:0]     buf_rd_addr;
    logic [DATA_W-1:0] buf_rd_data;

    // Advance the held transaction whenever the result register is free or
    // being drained this cycle.
    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_valid && s_ready) begin
            in_valid_next = 1'b1;
        end else if (advance) begin
            in_valid_next = 1'b0;
        end
    end

    always_comb begin
        out_valid_next = out_valid_reg;
        if (advance) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers: capture on accept, hold otherwise
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_item_reg <= s_payload;
        end
        if (advance) begin
            out_item_reg <= result;
        end
    end

    i2cscd_cmd_table #(
        .TABLE_ENTRIES (TABLE_ENTRIES)
    ) u_cmd_table (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_index (cfg_wr_index),
        .cfg_wr_data  (cfg_wr_data),
        .lookup_id    (in_item_reg.bus_data),
        .match        (match)
    );

    i2cscd_core #(
        .BUFFER_BYTES (BUFFER_BYTES),
        .AW           (AW)
    ) u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .advance (advance),
        .item    (in_item_reg),
        .match   (match),
        .rd_data (buf_rd_data),
        .wr_en   (buf_wr_en),
        .wr_addr (buf_wr_addr),
        .wr_data (buf_wr_data),
        .rd_addr (buf_rd_addr),
        .result  (result)
    );

    i2cscd_resp_buf #(
        .DEPTH (BUFFER_BYTES),
        .AW    (AW)
    ) u_resp_buf (
        .aclk    (aclk),
        .wr_en   (buf_wr_en),
        .wr_addr (buf_wr_addr),
        .wr_data (buf_wr_data),
        .rd_addr (buf_rd_addr),
        .rd_data (buf_rd_data)
    );

    assign m_valid   = out_valid_reg;
    assign m_payload = out_item_reg;

    // A stalled input transaction must stay put until it advances.
    `I2CSCD_ASSERT_NEXT(a_in_hold, aclk, aresetn, in_valid_reg && !advance, in_valid_reg && $stable(in_item_reg), "input transaction dropped or changed while stalled")
    // Back-pressure upstream only when a transaction is held.
    `I2CSCD_ASSERT_NOW(a_ready_low, aclk, aresetn, !s_ready, in_valid_reg && out_valid_reg && !m_ready, "s_ready low without a full pipeline")
    // A result never carries a transmit byte and a parameter byte together.
    `I2CSCD_ASSERT_NOW(a_tx_param_excl, aclk, aresetn, m_valid, !(m_payload.tx_valid && m_payload.param_valid), "tx and parameter byte in one result")
    // A bus error result carries nothing but the stop request and ack.
    `I2CSCD_ASSERT_NOW(a_stop_alone, aclk, aresetn, m_valid && m_payload.stop_request, !m_payload.tx_valid && !m_payload.param_valid && !m_payload.cmd_fire, "stop request mixed with other work")

endmodule

@@ dv/i2c_slave_command_dispatcher_test.sv @@
`timescale 1ns / 1ps

module i2c_slave_command_dispatcher_test;
    import i2cscd_pkg::*;

    // Bus events past the last named one; the block ignores them and leaves its state untouched.
    localparam logic [EVENT_W-1:0] EV_OTHER = 4'd10;
    localparam logic [EVENT_W-1:0] EV_MAX   = 4'd15;

    localparam int BUF_DEPTH     = BUFFER_BYTES_DEF;
    localparam int BUF_AW        = (BUF_DEPTH > 1) ? $clog2(BUF_DEPTH) : 1;
    localparam int TBL_DEPTH     = TABLE_ENTRIES_DEF;
    localparam int ITEM_TARGET   = 1350;
    localparam int RANDOM_PHASES = 8;
    // Covers the input register plus the result register, padded.
    localparam int SETTLE_CYCLES = 4;
    localparam int MAX_REPORTS   = 40;
    localparam int RUN_LIMIT_NS  = 2_000_000;

    logic                  aclk = 1'b0;
    logic                  aresetn;
    logic                  s_valid;
    logic                  s_ready;
    in_item_t              s_payload;
    logic                  m_valid;
    logic                  m_ready;
    out_item_t             m_payload;
    logic                  cfg_wr_en;
    logic [CFG_IDX_W-1:0]  cfg_wr_index;
    logic [CFG_DATA_W-1:0] cfg_wr_data;

    // Shadow copy of the command table as last written through the config port.
    logic [NUM_W-1:0]      num_cmds;
    logic [CFG_DATA_W-1:0] cmd_table [TBL_DEPTH];

    // Shadow copy of the dispatcher state, advanced once per accepted transaction.
    link_state_t           link_st;
    logic                  ack_en;
    logic [IDX_W-1:0]      active_cmd;
    logic [PCNT_W-1:0]     left_cnt;
    logic [PCNT_W-1:0]     send_total;
    logic [5:0]            load_cnt;
    logic [DATA_W-1:0]     resp_mem [BUF_DEPTH];

    // Results predicted for accepted transactions, oldest first.
    out_item_t             expected_results[$];
    out_item_t             want;

    // Idle control for both sides of the block.
    bit                    tx_idle_en;
    bit                    rx_idle_en;
    int                    rx_stall_left;
    int                    rx_hold_request;
    int                    rx_hold_left;

    int                    mismatch_count;
    int                    items_sent;
    int                    results_seen;
    int                    table_loads;
    int                    fires_expected;
    int                    params_expected;
    int                    tx_expected;
    int                    rejects_expected;

    i2c_slave_command_dispatcher dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_payload    (s_payload),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_payload    (m_payload),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_index (cfg_wr_index),
        .cfg_wr_data  (cfg_wr_data)
    );

    always #2 aclk = ~aclk;

    function automatic logic [DATA_W-1:0] rand_byte();
        return DATA_W'($urandom_range(0, 255));
    endfunction

    // ------------------------------------------------------------------
    // Command lookup and dispatch prediction
    // ------------------------------------------------------------------

    // Return the lowest table index whose id matches, or -1 on a miss.
    // Counts above the table size are clamped to the table size.
    function automatic int find_cmd(logic [DATA_W-1:0] id);
        int lim;
        lim = (num_cmds > TBL_DEPTH) ? TBL_DEPTH : int'(num_cmds);
        for (int i = 0; i < lim; i++) begin
            if (cmd_table[i][7:0] == id) return i;
        end
        return -1;
    endfunction

    // Advance the shadow state by one transaction and return the result it causes.
    function automatic out_item_t predict_dispatch(in_item_t it);
        out_item_t r;
        int k;
        logic [PCNT_W-1:0] pos;
        r = '0;
        if (it.opcode == OP_LOAD) begin
            // Store while there is room; the count saturates one past the
            // buffer so an overlong response is caught on its last byte.
            if (load_cnt < BUF_DEPTH) resp_mem[load_cnt[BUF_AW-1:0]] = it.response_byte;
            if (load_cnt <= BUF_DEPTH) load_cnt++;
            if (it.response_last) begin
                if (load_cnt <= BUF_DEPTH) begin
                    send_total = PCNT_W'(load_cnt);
                    left_cnt   = PCNT_W'(load_cnt);
                    link_st    = LS_SEND;
                end else begin
                    r.response_rejected = 1'b1;
                end
                load_cnt = '0;
            end
        end else begin
            case (it.bus_event)
                EV_BUS_ERROR: r.stop_request = 1'b1;
                EV_ARB_LOST: begin
                    ack_en = 1'b0;
                    r.start_request = 1'b1;
                end
                EV_RX_ADDR, EV_STOP, EV_TX_NACK, EV_TX_LAST: ack_en = 1'b1;
                EV_RX_NACK: ack_en = 1'b0;
                EV_RX_DATA: begin
                    if (link_st == LS_WAIT) begin
                        k = find_cmd(it.bus_data);
                        if (k < 0) begin
                            ack_en = 1'b0;
                        end else begin
                            ack_en = 1'b1;
                            r.cmd_index = IDX_W'(k);
                            if (cmd_table[k][12:8] == '0) begin
                                r.cmd_fire = 1'b1;
                            end else begin
                                active_cmd = IDX_W'(k);
                                left_cnt   = cmd_table[k][12:8];
                                link_st    = LS_RECEIVE;
                            end
                        end
                    end else if (link_st == LS_RECEIVE) begin
                        if (left_cnt == '0) begin
                            ack_en = 1'b0;
                        end else begin
                            r.param_valid = 1'b1;
                            r.param_byte  = it.bus_data;
                            r.cmd_index   = active_cmd;
                            left_cnt--;
                            ack_en = 1'b1;
                            if (left_cnt == '0) begin
                                r.cmd_fire = 1'b1;
                                active_cmd = '0;
                                link_st    = LS_WAIT;
                            end
                        end
                    end
                end
                EV_TX_ADDR, EV_TX_DATA: begin
                    if (link_st != LS_SEND || left_cnt == '0) begin
                        ack_en = 1'b0;
                    end else begin
                        pos = send_total - left_cnt;
                        r.tx_valid = 1'b1;
                        r.tx_byte  = (pos < BUF_DEPTH) ? resp_mem[pos[BUF_AW-1:0]] : '0;
                        left_cnt--;
                        if (left_cnt == '0) begin
                            link_st = LS_WAIT;
                            ack_en  = 1'b0;
                        end else begin
                            ack_en = 1'b1;
                        end
                    end
                end
                default: ;
            endcase
        end
        r.ack = ack_en;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Mismatch reporting and result checking
    // ------------------------------------------------------------------

    task automatic report_mismatch(string msg);
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
            $display("[%0t] result %0d: %s", $realtime, results_seen, msg);
    endtask

    task automatic check_field(string name, logic [DATA_W-1:0] got, logic [DATA_W-1:0] exp_val);
        if (got !== exp_val)
            report_mismatch($sformatf("%s is 0x%0h, expected 0x%0h", name, got, exp_val));
    endtask

    // Sample every accepted result at the rising edge and compare it with the
    // oldest prediction. Draw the receiver's stall for the next result here.
    always @(posedge aclk) begin
        if (aresetn === 1'b1 && m_valid === 1'b1 && m_ready === 1'b1) begin
            if (expected_results.size() == 0) begin
                report_mismatch("result transaction with no prediction pending");
            end else begin
                want = expected_results.pop_front();
                check_field("ack", DATA_W'(m_payload.ack), DATA_W'(want.ack));
                check_field("stop_request", DATA_W'(m_payload.stop_request),
                            DATA_W'(want.stop_request));
                check_field("start_request", DATA_W'(m_payload.start_request),
                            DATA_W'(want.start_request));
                check_field("tx_valid", DATA_W'(m_payload.tx_valid), DATA_W'(want.tx_valid));
                check_field("tx_byte", m_payload.tx_byte, want.tx_byte);
                check_field("param_valid", DATA_W'(m_payload.param_valid),
                            DATA_W'(want.param_valid));
                check_field("param_byte", m_payload.param_byte, want.param_byte);
                check_field("cmd_index", DATA_W'(m_payload.cmd_index),
                            DATA_W'(want.cmd_index));
                check_field("cmd_fire", DATA_W'(m_payload.cmd_fire), DATA_W'(want.cmd_fire));
                check_field("response_rejected", DATA_W'(m_payload.response_rejected),
                            DATA_W'(want.response_rejected));
            end
            results_seen++;
            rx_stall_left = rx_idle_en ? $urandom_range(0, 4) : 0;
        end
    end

    // Drive m_ready at the falling edge. A long hold-off, once requested,
    // is counted down here and takes priority over the per-result stall.
    initial begin
        m_ready = 1'b0;
        forever begin
            @(negedge aclk);
            if (rx_hold_request > 0) begin
                rx_hold_left    = rx_hold_request;
                rx_hold_request = 0;
            end
            if (rx_hold_left > 0) begin
                rx_hold_left--;
                m_ready <= 1'b0;
            end else if (rx_stall_left > 0) begin
                rx_stall_left--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------
    // Driving helpers
    // ------------------------------------------------------------------

    // Offer one transaction after a random gap, hold it until accepted, then
    // predict its result. Valid stays high on return so the next transaction
    // can follow back to back; anything else must drop it first.
    task automatic send_item(in_item_t it);
        int gap;
        out_item_t r;
        gap = tx_idle_en ? $urandom_range(0, 4) : 0;
        repeat (gap) begin
            @(negedge aclk);
            s_valid <= 1'b0;
        end
        @(negedge aclk);
        s_valid   <= 1'b1;
        s_payload <= it;
        do @(posedge aclk); while (s_ready !== 1'b1);
        r = predict_dispatch(it);
        expected_results.push_back(r);
        items_sent++;
        fires_expected   += int'(r.cmd_fire);
        params_expected  += int'(r.param_valid);
        tx_expected      += int'(r.tx_valid);
        rejects_expected += int'(r.response_rejected);
    endtask

    // Bus event; fill the unused load fields with noise.
    task automatic send_event(logic [EVENT_W-1:0] ev, logic [DATA_W-1:0] data);
        in_item_t it;
        it.opcode        = OP_EVENT;
        it.bus_event     = ev;
        it.bus_data      = data;
        it.response_byte = rand_byte();
        it.response_last = 1'($urandom_range(0, 1));
        send_item(it);
    endtask

    // Response byte load; fill the unused event fields with noise.
    task automatic send_load(logic [DATA_W-1:0] value, logic last);
        in_item_t it;
        it.opcode        = OP_LOAD;
        it.bus_event     = EVENT_W'($urandom_range(0, EV_MAX));
        it.bus_data      = rand_byte();
        it.response_byte = value;
        it.response_last = last;
        send_item(it);
    endtask

    // Drop valid, wait for every predicted result, then let the pipeline settle.
    task automatic wait_idle();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (expected_results.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // Write one register and mirror it in the shadow table. Call only while idle.
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
        @(negedge aclk);
        cfg_wr_en    <= 1'b1;
        cfg_wr_index <= idx;
        cfg_wr_data  <= value;
        @(negedge aclk);
        cfg_wr_en    <= 1'b0;
        if (idx == REG_NUM_COMMANDS) begin
            num_cmds = value[NUM_W-1:0];
            table_loads++;
        end else begin
            cmd_table[IDX_W'(idx - REG_CMD_ENTRY0)] = value;
        end
    endtask

    function automatic logic [CFG_DATA_W-1:0] cmd_entry(int count, logic [DATA_W-1:0] id);
        return {PCNT_W'(count), id};
    endfunction

    // Random table: all four entries live half the time, else none, a few, or a
    // count above the table size. Ids sometimes repeat the previous entry.
    task automatic load_random_table();
        int sel;
        logic [CFG_DATA_W-1:0] entry;
        logic [NUM_W-1:0] num;
        sel = $urandom_range(0, 7);
        if (sel == 0)     num = '0;
        else if (sel == 1) num = NUM_W'($urandom_range(5, 7));
        else if (sel < 4) num = NUM_W'($urandom_range(1, 3));
        else              num = NUM_W'(TBL_DEPTH);
        write_reg(REG_NUM_COMMANDS, CFG_DATA_W'(num));
        for (int i = 0; i < TBL_DEPTH; i++) begin
            entry[7:0] = rand_byte();
            if (i > 0 && $urandom_range(0, 5) == 0) entry[7:0] = cmd_table[i-1][7:0];
            entry[12:8] = ($urandom_range(0, 9) == 0) ? PCNT_W'(16)
                                                       : PCNT_W'($urandom_range(0, 4));
            write_reg(REG_CMD_ENTRY0 + CFG_IDX_W'(i), entry);
        end
    endtask

    // ------------------------------------------------------------------
    // Bus-level sequences
    // ------------------------------------------------------------------

    // Master write: address, command id, parameter bytes, then stop or NACK. Now and
    // then send one parameter too few or too many to break the framing.
    task automatic send_command_write();
        int lim;
        int k;
        int n;
        int twist;
        logic [DATA_W-1:0] id;
        lim = (num_cmds > TBL_DEPTH) ? TBL_DEPTH : int'(num_cmds);
        if (lim > 0 && $urandom_range(0, 3) != 0)
            id = cmd_table[$urandom_range(0, lim - 1)][7:0];
        else
            id = rand_byte();
        k = find_cmd(id);
        n = (k >= 0) ? int'(cmd_table[k][12:8]) : 0;
        twist = $urandom_range(0, 7);
        if (twist == 0 && n > 0) n--;
        else if (twist == 1) n++;
        send_event(EV_RX_ADDR, rand_byte());
        send_event(EV_RX_DATA, id);
        repeat (n) send_event(EV_RX_DATA, rand_byte());
        send_event(($urandom_range(0, 3) != 0) ? EV_STOP : EV_RX_NACK, rand_byte());
    endtask

    // Load a response of len bytes, then a master read of it. Occasionally
    // drop the last mark, or read fewer or more bytes than were loaded.
    task automatic send_response_read(int len);
        int ntx;
        bit mark;
        mark = ($urandom_range(0, 9) != 0);
        for (int i = 0; i < len; i++)
            send_load(rand_byte(), mark && (i == len - 1));
        ntx = ($urandom_range(0, 5) == 0) ? $urandom_range(0, len + 1) : len;
        if (ntx > 0) begin
            send_event(EV_TX_ADDR, rand_byte());
            repeat (ntx - 1) send_event(EV_TX_DATA, rand_byte());
        end
        send_event(($urandom_range(0, 1) != 0) ? EV_TX_NACK : EV_TX_LAST, rand_byte());
        send_event(EV_STOP, rand_byte());
    endtask

    // Unstructured traffic: any opcode, any event code, any field values.
    task automatic send_noise(int n);
        in_item_t it;
        repeat (n) begin
            it.opcode        = 1'($urandom_range(0, 1));
            it.bus_event     = EVENT_W'($urandom_range(0, EV_MAX));
            it.bus_data      = rand_byte();
            it.response_byte = rand_byte();
            it.response_last = 1'($urandom_range(0, 1));
            send_item(it);
        end
    endtask

    function automatic int pick_response_len();
        int sel;
        sel = $urandom_range(0, 9);
        if (sel == 0) return BUF_DEPTH;
        if (sel == 1) return $urandom_range(BUF_DEPTH + 1, BUF_DEPTH + 4);
        return $urandom_range(1, 6);
    endfunction

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Reset once, then check that an empty table NACKs a command id.
    task automatic test_reset_state();
        aresetn      = 1'b0;
        s_valid      = 1'b0;
        s_payload    = '0;
        cfg_wr_en    = 1'b0;
        cfg_wr_index = '0;
        cfg_wr_data  = '0;
        num_cmds     = '0;
        link_st      = LS_WAIT;
        ack_en       = 1'b1;
        active_cmd   = '0;
        left_cnt     = '0;
        send_total   = '0;
        load_cnt     = '0;
        for (int i = 0; i < TBL_DEPTH; i++) cmd_table[i] = '0;
        for (int i = 0; i < BUF_DEPTH; i++) resp_mem[i] = '0;
        tx_idle_en   = 1'b1;
        rx_idle_en   = 1'b1;
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        send_event(EV_RX_DATA, 8'h00);
        wait_idle();
    endtask

    // Walk each event code and the command, receive and send paths by hand.
    task automatic test_directed_events();
        write_reg(REG_NUM_COMMANDS, CFG_DATA_W'(TBL_DEPTH));
        write_reg(REG_CMD_ENTRY0 + 3'd0, cmd_entry(0, 8'h00));
        write_reg(REG_CMD_ENTRY0 + 3'd1, cmd_entry(1, 8'hFF));
        write_reg(REG_CMD_ENTRY0 + 3'd2, cmd_entry(2, 8'h5A));
        // Same id as entry 2; entry 2 must win.
        write_reg(REG_CMD_ENTRY0 + 3'd3, cmd_entry(1, 8'h5A));
        send_event(EV_BUS_ERROR, 8'hFF);
        send_event(EV_ARB_LOST, 8'h00);
        send_event(EV_RX_ADDR, 8'hA5);
        send_event(EV_RX_DATA, 8'h00);   // no parameters: fires at once
        send_event(EV_RX_DATA, 8'h5A);   // duplicate id, lowest index
        send_event(EV_RX_DATA, 8'hFF);
        send_event(EV_TX_ADDR, 8'h00);   // read while collecting parameters
        send_event(EV_RX_DATA, 8'h00);   // last parameter fires
        send_event(EV_RX_DATA, 8'h33);   // unknown id
        send_event(EV_RX_NACK, 8'h00);
        send_event(EV_STOP, 8'h00);
        send_event(EV_RX_DATA, 8'hFF);   // enter receive for entry 1
        send_load(8'hFF, 1'b0);          // response replaces the receive
        send_load(8'h00, 1'b0);
        send_load(8'hA5, 1'b1);
        send_event(EV_RX_DATA, 8'h12);   // ignored while sending
        send_event(EV_TX_ADDR, 8'h00);
        send_event(EV_TX_DATA, 8'h00);
        send_event(EV_TX_DATA, 8'h00);   // last byte: NACK after it
        send_event(EV_TX_DATA, 8'h00);   // nothing left to send
        send_event(EV_TX_NACK, 8'h00);
        send_event(EV_TX_LAST, 8'h00);
        send_event(EV_OTHER, 8'h5A);
        send_event(EV_MAX, 8'hA5);
        wait_idle();
    endtask

    // Table extremes: no commands, a count above the table size, one command.
    task automatic test_table_limits();
        write_reg(REG_NUM_COMMANDS, '0);
        write_reg(REG_CMD_ENTRY0 + 3'd0, cmd_entry(16, 8'hFF));
        write_reg(REG_CMD_ENTRY0 + 3'd1, cmd_entry(0, 8'h00));
        write_reg(REG_CMD_ENTRY0 + 3'd2, cmd_entry(0, 8'h81));
        write_reg(REG_CMD_ENTRY0 + 3'd3, cmd_entry(3, 8'h7E));
        send_event(EV_RX_DATA, 8'hFF);
        send_event(EV_RX_DATA, 8'h00);
        wait_idle();
        // Seven is clamped to the table size.
        write_reg(REG_NUM_COMMANDS, CFG_DATA_W'(7));
        send_event(EV_RX_ADDR, 8'h00);
        send_event(EV_RX_DATA, 8'hFF);
        for (int i = 0; i < 16; i++) send_event(EV_RX_DATA, (i % 2) ? 8'hFF : 8'h00);
        send_event(EV_RX_DATA, 8'h7E);
        repeat (3) send_event(EV_RX_DATA, rand_byte());
        send_event(EV_STOP, 8'h00);
        wait_idle();
        write_reg(REG_NUM_COMMANDS, CFG_DATA_W'(1));
        send_event(EV_RX_DATA, 8'h00);   // entry 1 lies outside the live range
        send_event(EV_STOP, 8'h00);
        wait_idle();
    endtask

    // Hold the result side off long enough for the block to fill and stall
    // its input, then pause the sender until everything has drained.
    task automatic test_backpressure();
        load_random_table();
        tx_idle_en = 1'b0;
        rx_idle_en = 1'b0;
        rx_hold_request = 60;
        send_response_read(4);
        send_command_write();
        send_response_read(5);
        wait_idle();
        rx_idle_en = 1'b1;
        rx_hold_request = 40;
        send_noise(20);
        wait_idle();
    endtask

    // Mostly well-formed reads and writes with random content, with noise and
    // broken framing mixed in. Each phase loads a new table and idle pattern.
    task automatic test_random_traffic();
        int phase_end;
        int sel;
        for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
            wait_idle();
            load_random_table();
            tx_idle_en = (ph % 4 == 0) || (ph % 4 == 2);
            rx_idle_en = (ph % 4 == 0) || (ph % 4 == 3);
            phase_end = items_sent + (ITEM_TARGET - items_sent) / (RANDOM_PHASES - ph);
            // Open each phase with a response that cannot fit.
            send_response_read($urandom_range(BUF_DEPTH + 1, BUF_DEPTH + 4));
            while (items_sent < phase_end) begin
                sel = $urandom_range(0, 9);
                if (sel < 4)      send_command_write();
                else if (sel < 7) send_response_read(pick_response_len());
                else              send_noise($urandom_range(1, 4));
            end
        end
        tx_idle_en = 1'b1;
        rx_idle_en = 1'b1;
        wait_idle();
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------

    initial begin
        test_reset_state();
        test_directed_events();
        test_table_limits();
        test_backpressure();
        test_random_traffic();
        $display("Sent %0d transactions, checked %0d results across %0d command table loads.",
                 items_sent, results_seen, table_loads);
        $display("Covered %0d command fires, %0d parameter bytes, %0d sent bytes, %0d rejects.",
                 fires_expected, params_expected, tx_expected, rejects_expected);
        if (mismatch_count == 0 && expected_results.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

    // Abort a hung run.
    initial begin
        #(RUN_LIMIT_NS);
        $display("Timeout with %0d results still pending.", expected_results.size());
        $display("CHECKS FAILED");
        $finish;
    end

endmodule
